// ===== hdl/sfsp_pkg.sv =====
// Shared constants, types and helper functions of the scored-fit shelf packer.
package sfsp_pkg;

    localparam int MAX_BINS    = 16;
    localparam int MAX_SHELVES = 16;
    localparam int DIM_BITS    = 16;

    localparam int BIN_IW = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
    localparam int SHF_IW = (MAX_SHELVES > 1) ? $clog2(MAX_SHELVES) : 1;
    localparam int BIN_CW = $clog2(MAX_BINS + 1);
    localparam int SHF_CW = $clog2(MAX_SHELVES + 1);
    localparam int SLOT_W = BIN_IW + SHF_IW;
    localparam int SLOTS  = 2 ** SLOT_W;

    // Signed differences of dimensions against the 16-bit bin sizes
    localparam int CMP_W  = ((DIM_BITS > 16) ? DIM_BITS : 16) + 2;
    localparam int AREA_W = 2 * DIM_BITS + 1;
    localparam int KEY_W  = (AREA_W > CMP_W) ? AREA_W : CMP_W;

    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;

    localparam logic [1:0] REG_BIN_WIDTH  = 2'd0;
    localparam logic [1:0] REG_BIN_HEIGHT = 2'd1;
    localparam logic [1:0] REG_SCORE_MODE = 2'd2;

    localparam logic [2:0] MODE_BEST_WIDTH   = 3'd0;
    localparam logic [2:0] MODE_WORST_WIDTH  = 3'd1;
    localparam logic [2:0] MODE_BEST_HEIGHT  = 3'd2;
    localparam logic [2:0] MODE_WORST_HEIGHT = 3'd3;
    localparam logic [2:0] MODE_BEST_AREA    = 3'd4;
    localparam logic [2:0] MODE_WORST_AREA   = 3'd5;

    typedef struct packed {
        logic [15:0] item_width;
        logic [15:0] item_height;
        logic        allow_rotation;
    } t_in_item;

    typedef struct packed {
        logic [15:0] pos_x;
        logic [15:0] pos_y;
        logic [3:0]  bin_number;
        logic        rotated;
        logic        full_res;
    } t_out_item;

    typedef struct packed {
        logic [DIM_BITS-1:0] offset;
        logic [DIM_BITS-1:0] height;
        logic [DIM_BITS-1:0] used;
    } t_shelf;

    typedef struct packed {
        logic              accept;
        logic              rd_en;
        logic [BIN_IW-1:0] rd_bin;
        logic [SHF_IW-1:0] rd_shelf;
        logic [BIN_IW-1:0] cur_bin;
        logic [SHF_IW-1:0] cur_shelf;
        logic              scan;
        logic              last_shelf;
        logic              open;
        logic              finish;
    } t_dp_cmd;

    typedef struct packed {
        logic [SHF_CW-1:0] shelf_cnt;
        logic [BIN_CW-1:0] bin_cnt;
        logic              out_free;
    } t_dp_sts;

    function automatic logic orient(input logic allow, input logic [DIM_BITS-1:0] w,
                                    input logic [DIM_BITS-1:0] h,
                                    input logic [DIM_BITS-1:0] sh);
        logic [DIM_BITS-1:0] longer;
        logic                want_vert;
        longer    = (w > h) ? w : h;
        want_vert = (longer <= sh);
        if (!allow || (w == h)) begin
            return 1'b0;
        end
        return want_vert != (h > w);
    endfunction

    function automatic logic [DIM_BITS-1:0] sat_add(input logic [DIM_BITS-1:0] a,
                                                    input logic [DIM_BITS-1:0] b);
        logic [DIM_BITS:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[DIM_BITS] ? {DIM_BITS{1'b1}} : s[DIM_BITS-1:0];
    endfunction

endpackage

// ===== hdl/scored_fit_shelf_packer_top.sv =====
// Top level of the scored-fit shelf packer: register port, sequencer and datapath.
//
//  channel   direction  handshake                 payload
//  in        to block   i_in_valid / o_in_stall   i_in_item  (t_in_item)
//  out       from block o_out_valid / i_out_stall o_out_item (t_out_item)
//  config    to block   psel, penable, pwrite     paddr, pwdata, prdata
//
// An item is placed by walking the shelves of every bin in use, up to 16 bins of 16 shelves:
// one stored shelf is read and scored per cycle from the shelf memory, plus one shelf-open
// step per bin and one commit step.
// Reset is synchronous: one bin with one empty shelf, no memory clearing pass.
// The block takes one item at a time; a result held by i_out_stall blocks the commit
// of the next item only.
module scored_fit_shelf_packer_top (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  sfsp_pkg::t_in_item                 i_in_item,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output sfsp_pkg::t_out_item                o_out_item,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [sfsp_pkg::PADDR_W-1:0]       paddr,
    input  logic [sfsp_pkg::PDATA_W-1:0]       pwdata,
    output logic [sfsp_pkg::PDATA_W-1:0]       prdata,
    output logic                               pready
);

    logic [15:0]         r_bin_width;
    logic [15:0]         r_bin_height;
    logic [2:0]          r_score_mode;
    logic [1:0]          reg_idx;
    sfsp_pkg::t_dp_cmd   cmd;
    sfsp_pkg::t_dp_sts   sts;

    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bin_width  <= 16'd1024;
            r_bin_height <= 16'd1024;
            r_score_mode <= sfsp_pkg::MODE_BEST_WIDTH;
        end else if (psel && penable && pwrite) begin
            unique case (reg_idx)
                sfsp_pkg::REG_BIN_WIDTH:  r_bin_width  <= pwdata[15:0];
                sfsp_pkg::REG_BIN_HEIGHT: r_bin_height <= pwdata[15:0];
                sfsp_pkg::REG_SCORE_MODE: r_score_mode <= pwdata[2:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            sfsp_pkg::REG_BIN_WIDTH:  prdata = sfsp_pkg::PDATA_W'(r_bin_width);
            sfsp_pkg::REG_BIN_HEIGHT: prdata = sfsp_pkg::PDATA_W'(r_bin_height);
            sfsp_pkg::REG_SCORE_MODE: prdata = sfsp_pkg::PDATA_W'(r_score_mode);
            default:                  prdata = '0;
        endcase
    end

    sfsp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    sfsp_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .i_item       (i_in_item),
        .i_bin_width  (r_bin_width),
        .i_bin_height (r_bin_height),
        .i_score_mode (r_score_mode),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_out_item   (o_out_item)
    );

endmodule

// ===== hdl/sfsp_ctrl.sv =====
// Sequencer that walks the shelves of every bin in use and commits one item.
module sfsp_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  sfsp_pkg::t_dp_sts   i_sts,
    output sfsp_pkg::t_dp_cmd   o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_START,
        S_SCAN,
        S_OPEN,
        S_FIN
    } t_state;

    t_state                        r_state, n_state;
    logic [sfsp_pkg::BIN_IW-1:0]   r_bin, n_bin;
    logic [sfsp_pkg::SHF_IW-1:0]   r_shelf, n_shelf;
    logic                          last_shelf;
    logic                          more_bins;

    assign last_shelf = (sfsp_pkg::SHF_CW'(r_shelf) + sfsp_pkg::SHF_CW'(1)) == i_sts.shelf_cnt;
    assign more_bins  = (sfsp_pkg::BIN_CW'(r_bin) + sfsp_pkg::BIN_CW'(1)) < i_sts.bin_cnt;
    assign o_in_stall = (r_state != S_IDLE);

    always_comb begin
        n_state = r_state;
        n_bin   = r_bin;
        n_shelf = r_shelf;
        o_cmd   = '0;
        o_cmd.cur_bin    = r_bin;
        o_cmd.cur_shelf  = r_shelf;
        o_cmd.last_shelf = last_shelf;
        o_cmd.rd_bin     = r_bin;
        o_cmd.rd_shelf   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_bin   = '0;
                    n_shelf = '0;
                    n_state = S_START;
                end
            end
            S_START: begin
                o_cmd.rd_en = 1'b1;
                n_state     = S_SCAN;
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (last_shelf) begin
                    n_state = S_OPEN;
                end else begin
                    // fetch the next shelf while this one is scored
                    o_cmd.rd_en    = 1'b1;
                    o_cmd.rd_shelf = r_shelf + 1'b1;
                    n_shelf        = r_shelf + 1'b1;
                end
            end
            S_OPEN: begin
                o_cmd.open = 1'b1;
                if (more_bins) begin
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_bin = r_bin + 1'b1;
                    n_bin        = r_bin + 1'b1;
                    n_shelf      = '0;
                    n_state      = S_SCAN;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (i_sts.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_bin   <= '0;
            r_shelf <= '0;
        end else begin
            r_state <= n_state;
            r_bin   <= n_bin;
            r_shelf <= n_shelf;
        end
    end

    a_scan_bin_in_use: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (sfsp_pkg::BIN_CW'(r_bin) < i_sts.bin_cnt))
        else $error("scan beyond bins in use");

    a_scan_shelf_in_bin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (sfsp_pkg::SHF_CW'(r_shelf) < i_sts.shelf_cnt))
        else $error("scan beyond shelves of bin");

    a_open_after_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OPEN) |-> ($past(r_state) == S_SCAN))
        else $error("shelf-open step not preceded by a scan");

endmodule

// ===== hdl/sfsp_dp.sv =====
// Shelf store, fit and score logic, best-candidate registers and result register.
module sfsp_dp (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  sfsp_pkg::t_dp_cmd     i_cmd,
    output sfsp_pkg::t_dp_sts     o_sts,
    input  sfsp_pkg::t_in_item    i_item,
    input  logic [15:0]           i_bin_width,
    input  logic [15:0]           i_bin_height,
    input  logic [2:0]            i_score_mode,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output sfsp_pkg::t_out_item   o_out_item
);

    localparam int D = sfsp_pkg::DIM_BITS;

    sfsp_pkg::t_shelf               r_mem [sfsp_pkg::SLOTS];
    sfsp_pkg::t_shelf               r_rd_raw;
    logic                           r_rd_blank;
    logic                           r_slot0_valid;
    logic [sfsp_pkg::SHF_CW-1:0]    r_shelf_cnt [sfsp_pkg::MAX_BINS];
    logic [sfsp_pkg::BIN_CW-1:0]    r_bins_used;

    logic [D-1:0]                   r_iw, r_ih;
    logic                           r_allow;

    logic                           r_have;
    logic [sfsp_pkg::KEY_W-1:0]     r_best_key;
    logic [sfsp_pkg::BIN_IW-1:0]    r_best_bin;
    logic [sfsp_pkg::SHF_IW-1:0]    r_best_shelf;
    logic                           r_best_rot;
    sfsp_pkg::t_shelf               r_best_data;

    logic                           r_out_valid;
    sfsp_pkg::t_out_item            r_out;

    sfsp_pkg::t_shelf               rd;
    logic [sfsp_pkg::SLOT_W-1:0]    rd_addr;
    logic [sfsp_pkg::SHF_CW-1:0]    cur_cnt;
    logic                           rot;
    logic [D-1:0]                   w, h, used_k, sh_k;
    logic [sfsp_pkg::CMP_W-1:0]     bw, bh, d_bw, d_h;
    logic                           fit;
    logic [D:0]                     wsum;
    logic [D-1:0]                   tall;
    logic [sfsp_pkg::AREA_W-1:0]    area;
    logic [sfsp_pkg::KEY_W-1:0]     key;
    logic                           better;
    logic                           open_ok;
    logic [D-1:0]                   new_off;
    logic [sfsp_pkg::SHF_IW-1:0]    new_shelf;

    logic                           fin_full;
    logic [sfsp_pkg::BIN_IW-1:0]    fin_bin;
    logic [sfsp_pkg::SHF_IW-1:0]    fin_shelf;
    logic                           fin_rot;
    sfsp_pkg::t_shelf               fin_data;
    logic [D-1:0]                   fin_w, fin_h;
    sfsp_pkg::t_shelf               fin_upd;

    logic                           wr_en;
    logic [sfsp_pkg::SLOT_W-1:0]    wr_addr;
    sfsp_pkg::t_shelf               wr_data;

    assign rd      = r_rd_blank ? '0 : r_rd_raw;
    assign rd_addr = {i_cmd.rd_bin, i_cmd.rd_shelf};
    assign cur_cnt = r_shelf_cnt[i_cmd.cur_bin];
    assign bw      = sfsp_pkg::CMP_W'(i_bin_width);
    assign bh      = sfsp_pkg::CMP_W'(i_bin_height);

    assign o_sts.shelf_cnt = cur_cnt;
    assign o_sts.bin_cnt   = r_bins_used;
    assign o_sts.out_free  = !r_out_valid || !i_out_stall;

    // Fit and score of the shelf in the read register; a new empty shelf while opening
    always_comb begin
        rot    = sfsp_pkg::orient(r_allow, r_iw, r_ih, rd.height);
        w      = rot ? r_ih : r_iw;
        h      = rot ? r_iw : r_ih;
        used_k = i_cmd.open ? '0 : rd.used;
        sh_k   = i_cmd.open ? '0 : rd.height;
        fit    = (sfsp_pkg::CMP_W'(w) + sfsp_pkg::CMP_W'(rd.used)) <= bw;
        if (i_cmd.last_shelf) begin
            fit = fit && ((sfsp_pkg::CMP_W'(rd.offset) + sfsp_pkg::CMP_W'(h)) <= bh);
        end else begin
            fit = fit && (h <= rd.height);
        end
        d_bw = sfsp_pkg::CMP_W'(w) + sfsp_pkg::CMP_W'(used_k) - bw;
        d_h  = sfsp_pkg::CMP_W'(h) - sfsp_pkg::CMP_W'(sh_k);
        wsum = {1'b0, used_k} + {1'b0, w};
        tall = (h > sh_k) ? h : sh_k;
        area = sfsp_pkg::AREA_W'(wsum) * sfsp_pkg::AREA_W'(tall);
        case (i_score_mode)
            sfsp_pkg::MODE_WORST_WIDTH:
                key = sfsp_pkg::KEY_W'({d_bw[sfsp_pkg::CMP_W-1],
                                        ~(d_bw[sfsp_pkg::CMP_W-2:0])} + 1'b1);
            sfsp_pkg::MODE_BEST_HEIGHT:
                key = sfsp_pkg::KEY_W'({~d_h[sfsp_pkg::CMP_W-1], d_h[sfsp_pkg::CMP_W-2:0]});
            sfsp_pkg::MODE_WORST_HEIGHT:
                key = sfsp_pkg::KEY_W'({d_h[sfsp_pkg::CMP_W-1],
                                        ~(d_h[sfsp_pkg::CMP_W-2:0])} + 1'b1);
            sfsp_pkg::MODE_BEST_AREA:  key = sfsp_pkg::KEY_W'(area);
            sfsp_pkg::MODE_WORST_AREA: key = sfsp_pkg::KEY_W'(~area);
            default:
                key = sfsp_pkg::KEY_W'({~d_bw[sfsp_pkg::CMP_W-1], d_bw[sfsp_pkg::CMP_W-2:0]});
        endcase
        better    = !r_have || (key > r_best_key);
        open_ok   = !r_have && (cur_cnt < sfsp_pkg::SHF_CW'(sfsp_pkg::MAX_SHELVES))
                    && ((sfsp_pkg::CMP_W'(rd.offset) + sfsp_pkg::CMP_W'(rd.height)
                         + sfsp_pkg::CMP_W'(h)) <= bh);
        new_off   = sfsp_pkg::sat_add(rd.offset, rd.height);
        new_shelf = cur_cnt[sfsp_pkg::SHF_IW-1:0];
    end

    // Final placement: best candidate, else a fresh bin, else full
    always_comb begin
        fin_full  = 1'b0;
        fin_bin   = r_best_bin;
        fin_shelf = r_best_shelf;
        fin_rot   = r_best_rot;
        fin_data  = r_best_data;
        if (!r_have) begin
            fin_full  = (r_bins_used >= sfsp_pkg::BIN_CW'(sfsp_pkg::MAX_BINS));
            fin_bin   = r_bins_used[sfsp_pkg::BIN_IW-1:0];
            fin_shelf = '0;
            fin_rot   = r_allow && (r_ih > r_iw);
            fin_data  = '0;
        end
        fin_w = fin_rot ? r_ih : r_iw;
        fin_h = fin_rot ? r_iw : r_ih;
        fin_upd.offset = fin_data.offset;
        fin_upd.height = (fin_h > fin_data.height) ? fin_h : fin_data.height;
        fin_upd.used   = sfsp_pkg::sat_add(fin_data.used, fin_w);
    end

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = {i_cmd.cur_bin, new_shelf};
        wr_data = '{offset: new_off, height: '0, used: '0};
        if (i_cmd.open && open_ok) begin
            wr_en = 1'b1;
        end else if (i_cmd.finish && !fin_full) begin
            wr_en   = 1'b1;
            wr_addr = {fin_bin, fin_shelf};
            wr_data = fin_upd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (i_cmd.rd_en) begin
            r_rd_raw <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot0_valid <= 1'b0;
            r_rd_blank    <= 1'b0;
            r_bins_used   <= sfsp_pkg::BIN_CW'(1);
            for (int i = 0; i < sfsp_pkg::MAX_BINS; i++) begin
                r_shelf_cnt[i] <= sfsp_pkg::SHF_CW'(1);
            end
            r_have      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (wr_en && (wr_addr == '0)) begin
                r_slot0_valid <= 1'b1;
            end
            // the first shelf of bin 0 reads as empty until it is written
            if (i_cmd.rd_en) begin
                r_rd_blank <= (rd_addr == '0) && !r_slot0_valid;
            end
            if (i_cmd.accept) begin
                r_have <= 1'b0;
            end else if (i_cmd.scan && fit && better) begin
                r_have <= 1'b1;
            end else if (i_cmd.open && open_ok) begin
                r_have <= 1'b1;
            end
            if (i_cmd.open && open_ok) begin
                r_shelf_cnt[i_cmd.cur_bin] <= cur_cnt + 1'b1;
            end
            if (i_cmd.finish && !r_have && !fin_full) begin
                r_bins_used          <= r_bins_used + 1'b1;
                r_shelf_cnt[fin_bin] <= sfsp_pkg::SHF_CW'(1);
            end
            if (i_cmd.finish) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_iw    <= D'(i_item.item_width);
            r_ih    <= D'(i_item.item_height);
            r_allow <= i_item.allow_rotation;
        end
        if (i_cmd.scan && fit && better) begin
            r_best_key   <= key;
            r_best_bin   <= i_cmd.cur_bin;
            r_best_shelf <= i_cmd.cur_shelf;
            r_best_rot   <= rot;
            r_best_data  <= rd;
        end else if (i_cmd.open && open_ok) begin
            r_best_key   <= key;
            r_best_bin   <= i_cmd.cur_bin;
            r_best_shelf <= new_shelf;
            r_best_rot   <= rot;
            r_best_data  <= '{offset: new_off, height: '0, used: '0};
        end
        if (i_cmd.finish) begin
            if (fin_full) begin
                r_out <= '{pos_x: '0, pos_y: '0, bin_number: '0, rotated: 1'b0,
                           full_res: 1'b1};
            end else begin
                r_out <= '{pos_x: 16'(fin_data.used), pos_y: 16'(fin_data.offset),
                           bin_number: 4'(fin_bin), rotated: fin_rot, full_res: 1'b0};
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule

// ===== sim/scored_fit_shelf_packer_top_tb.sv =====
// Self-checking testbench of the scored-fit shelf packer: random and directed items.
`timescale 1ns / 1ps

module scored_fit_shelf_packer_top_tb;
    import sfsp_pkg::*;

    localparam int NB = 16;
    localparam int NS = 16;
    localparam longint unsigned DMAX = 64'hFFFF;
    localparam int HOLD_CYCLES = 3000;
    localparam int DRAIN_CYCLES = 300;
    localparam int WATCHDOG_LIMIT = 20000;

    // Shelf packing predictor and queue of expected placements
    class placement_board;
        longint unsigned bin_w, bin_h;
        bit [2:0] mode;
        longint unsigned offs[NB*NS];
        longint unsigned hts[NB*NS];
        longint unsigned used[NB*NS];
        int nshelf[NB];
        int nbins;
        t_out_item placements[$];
        int errors;

        function new();
            bin_w = 1024;
            bin_h = 1024;
            mode = MODE_BEST_WIDTH;
            foreach (offs[i]) begin
                offs[i] = 0;
                hts[i] = 0;
                used[i] = 0;
            end
            foreach (nshelf[i]) nshelf[i] = 1;
            nbins = 1;
            errors = 0;
        endfunction

        function void set_reg(logic [1:0] idx, logic [31:0] val);
            case (idx)
                REG_BIN_WIDTH: begin
                    bin_w = val[15:0];
                end
                REG_BIN_HEIGHT: begin
                    bin_h = val[15:0];
                end
                REG_SCORE_MODE: begin
                    mode = val[2:0];
                end
                default: ;
            endcase
        endfunction

        function longint unsigned sat(longint unsigned a, longint unsigned b);
            return (a + b > DMAX) ? DMAX : a + b;
        endfunction

        function bit turn(bit allow, longint unsigned w, longint unsigned h,
                          longint unsigned sh);
            longint unsigned longer;
            longer = (w > h) ? w : h;
            if (!allow || w == h) return 1'b0;
            return (longer <= sh) != (h > w);
        endfunction

        function longint unsigned flip(longint s);
            return longint'(s) ^ (64'd1 << 63);
        endfunction

        function longint unsigned fit_score(longint unsigned w, longint unsigned h,
                                            longint unsigned u, longint unsigned sh);
            longint avail;
            longint unsigned tall, area;
            avail = longint'(bin_w) - longint'(u);
            tall = (h > sh) ? h : sh;
            area = (u + w) * tall;
            case (mode)
                MODE_WORST_WIDTH:  return flip(avail - longint'(w));
                MODE_BEST_HEIGHT:  return flip(longint'(h) - longint'(sh));
                MODE_WORST_HEIGHT: return flip(longint'(sh) - longint'(h));
                MODE_BEST_AREA:    return area;
                MODE_WORST_AREA:   return ~area;
                default:           return flip(longint'(w) - avail);
            endcase
        endfunction

        function t_out_item place(t_in_item it);
            longint unsigned iw, ih, w, h, best, k;
            bit allow, have, fit;
            bit r, brot;
            int bb, bs, n, idx, top;
            longint avail;
            t_out_item res;
            iw = it.item_width;
            ih = it.item_height;
            allow = it.allow_rotation;
            have = 0;
            best = 0;
            bb = 0;
            bs = 0;
            brot = 0;
            res = '0;
            for (int b = 0; b < nbins; b++) begin
                n = nshelf[b];
                r = 0;
                for (int s = 0; s < n; s++) begin
                    idx = b * NS + s;
                    r = turn(allow, iw, ih, hts[idx]);
                    w = r ? ih : iw;
                    h = r ? iw : ih;
                    avail = longint'(bin_w) - longint'(used[idx]);
                    fit = longint'(w) <= avail;
                    if (s == n - 1) fit = fit && (offs[idx] + h <= bin_h);
                    else fit = fit && (h <= hts[idx]);
                    if (fit) begin
                        k = fit_score(w, h, used[idx], hts[idx]);
                        if (!have || k > best) begin
                            have = 1;
                            best = k;
                            bb = b;
                            bs = s;
                            brot = r;
                        end
                    end
                end
                // open a shelf above the top one while nothing has fitted
                if (!have && n < NS) begin
                    top = b * NS + n - 1;
                    h = r ? iw : ih;
                    w = r ? ih : iw;
                    if (offs[top] + hts[top] + h <= bin_h) begin
                        idx = b * NS + n;
                        offs[idx] = sat(offs[top], hts[top]);
                        hts[idx] = 0;
                        used[idx] = 0;
                        nshelf[b] = n + 1;
                        have = 1;
                        best = fit_score(w, h, 0, 0);
                        bb = b;
                        bs = n;
                        brot = r;
                    end
                end
            end
            if (!have) begin
                if (nbins >= NB) begin
                    res.full_res = 1'b1;
                    return res;
                end
                bb = nbins;
                nbins++;
                nshelf[bb] = 1;
                idx = bb * NS;
                offs[idx] = 0;
                hts[idx] = 0;
                used[idx] = 0;
                bs = 0;
                brot = allow && (ih > iw);
            end
            idx = bb * NS + bs;
            w = brot ? ih : iw;
            h = brot ? iw : ih;
            res.pos_x = used[idx][15:0];
            res.pos_y = offs[idx][15:0];
            res.bin_number = bb[3:0];
            res.rotated = brot;
            if (h > hts[idx]) hts[idx] = h;
            used[idx] = sat(used[idx], w);
            return res;
        endfunction

        function void note_item(t_in_item it);
            placements = {placements, place(it)};
        endfunction

        function void check_result(t_out_item got);
            t_out_item want;
            if (placements.size() == 0) begin
                errors++;
                $display("%0t: unexpected result x=%0d y=%0d bin=%0d rot=%0d full=%0d",
                         $time, got.pos_x, got.pos_y, got.bin_number, got.rotated,
                         got.full_res);
                return;
            end
            want = placements.pop_front();
            if (got !== want) begin
                errors++;
                $display("%0t: expected x=%0d y=%0d bin=%0d rot=%0d full=%0d, got x=%0d y=%0d bin=%0d rot=%0d full=%0d",
                         $time, want.pos_x, want.pos_y, want.bin_number, want.rotated,
                         want.full_res, got.pos_x, got.pos_y, got.bin_number, got.rotated,
                         got.full_res);
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    logic i_in_valid;
    logic o_in_stall;
    t_in_item i_in_item;
    logic o_out_valid;
    logic i_out_stall;
    t_out_item o_out_item;
    logic psel, penable, pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic pready;

    placement_board board;
    int stall_pct;
    bit long_hold;
    bit no_idle;
    int quiet_cycles;

    scored_fit_shelf_packer_top dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall), .i_in_item(i_in_item),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall), .o_out_item(o_out_item),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always begin
        i_clk = 1'b1;
        #10;
        i_clk = 1'b0;
        #10;
    end

    // Sample handshakes on the edge that completes them
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) begin
                board.note_item(i_in_item);
            end
            if (o_out_valid && !i_out_stall) begin
                board.check_result(o_out_item);
            end
            if (psel && penable && pwrite && pready) begin
                board.set_reg(paddr[3:2], pwdata);
            end
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)
                || (psel && penable && pwrite && pready)) begin
                quiet_cycles <= 0;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    always @(posedge i_clk) begin
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 60) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(20, 200);
    endfunction

    // Receiver: random stalls, one long hold-off on request
    initial begin
        i_out_stall = 1'b0;
        forever begin
            @(posedge i_clk);
            if (long_hold) begin
                i_out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                long_hold = 0;
                i_out_stall <= 1'b0;
            end else if (pick_gap() > 0 && $urandom_range(0, 99) < stall_pct) begin
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    task automatic write_reg(logic [1:0] idx, logic [31:0] val);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic send_item(logic [15:0] w, logic [15:0] h, logic rot);
        int gap;
        i_in_valid <= 1'b1;
        i_in_item <= '{item_width: w, item_height: h, allow_rotation: rot};
        do @(posedge i_clk); while (o_in_stall);
        gap = pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Hold the sender until every placement has come back, then let the block settle
    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (board.placements.size() > 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic run_phase(int bw, int bh, logic [2:0] md, int count, int maxdim);
        logic [15:0] w, h;
        write_reg(REG_BIN_WIDTH, bw);
        write_reg(REG_BIN_HEIGHT, bh);
        write_reg(REG_SCORE_MODE, md);
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(0, 9) == 0) begin
                w = $urandom;
                h = $urandom;
            end else begin
                w = $urandom_range(0, maxdim);
                h = $urandom_range(0, maxdim);
            end
            send_item(w, h, $urandom_range(0, 1));
        end
        drain();
    endtask

    initial begin
        board = new();
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in_item = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        quiet_cycles = 0;
        stall_pct = 30;
        long_hold = 0;
        no_idle = 0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: zero sizes, squares, rotation either way, open shelf growth, huge items
        send_item(16'd0, 16'd0, 1'b0);
        send_item(16'd0, 16'd0, 1'b1);
        send_item(16'd100, 16'd100, 1'b1);
        send_item(16'd200, 16'd50, 1'b1);
        send_item(16'd50, 16'd200, 1'b1);
        send_item(16'd50, 16'd200, 1'b0);
        send_item(16'd300, 16'd80, 1'b1);
        send_item(16'd80, 16'd30, 1'b1);
        send_item(16'd1024, 16'd1, 1'b0);
        send_item(16'd1, 16'd1024, 1'b1);
        send_item(16'd900, 16'd500, 1'b0);
        send_item(16'd600, 16'd600, 1'b0);
        send_item(16'hFFFF, 16'd10, 1'b0);
        send_item(16'd10, 16'hFFFF, 1'b1);
        send_item(16'hFFFF, 16'hFFFF, 1'b1);
        send_item(16'd5, 16'd5, 1'b0);
        drain();

        run_phase(1024, 1024, MODE_BEST_WIDTH, 250, 400);
        run_phase(4096, 2048, MODE_WORST_WIDTH, 250, 800);
        stall_pct = 70;
        run_phase(65535, 65535, MODE_BEST_HEIGHT, 250, 5000);
        stall_pct = 20;
        long_hold = 1;
        run_phase(65535, 65535, MODE_WORST_HEIGHT, 250, 5000);
        run_phase(30000, 65535, MODE_BEST_AREA, 250, 3000);
        no_idle = 1;
        stall_pct = 0;
        run_phase(65535, 40000, MODE_WORST_AREA, 250, 3000);
        no_idle = 0;
        stall_pct = 30;
        run_phase(65535, 65535, 3'd6, 60, 2000);
        run_phase(65535, 65535, 3'd7, 140, 65535);
        run_phase(1, 1, MODE_BEST_WIDTH, 100, 2);

        if (board.errors == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end
endmodule
